@@ rtl/fmb_pkg.sv @@
`default_nettype none
package fmb_pkg;

  localparam int unsigned MAX_PAYLOAD = 250;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_SYNC  = 2'd1;
  localparam logic [1:0] CFG_END   = 2'd2;

  localparam logic [7:0] START_RST = 8'd36;
  localparam logic [7:0] SYNC_RST  = 8'd64;
  localparam logic [7:0] END_RST   = 8'd42;

  localparam logic [2:0] STEP_START = 3'd0;
  localparam logic [2:0] STEP_SYNC  = 3'd1;
  localparam logic [2:0] STEP_TYPE  = 3'd2;
  localparam logic [2:0] STEP_LEN   = 3'd3;
  localparam logic [2:0] STEP_DATA  = 3'd4;
  localparam logic [2:0] STEP_END   = 3'd5;
  localparam logic [2:0] STEP_SYNC2 = 3'd6;
  localparam logic [2:0] STEP_CSUM  = 3'd7;

  typedef struct packed {
    logic       hdr;
    logic       has_data;
    logic       trl;
    logic [7:0] msg_type;
    logic [7:0] payload_len;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] sync_char;
    logic [7:0] end_char;
  } cfg_t;

  function automatic logic [2:0] first_step(input cmd_t c);
    logic [2:0] s;
    if (c.hdr) s = STEP_START;
    else if (c.has_data) s = STEP_DATA;
    else s = STEP_END;
    return s;
  endfunction

  function automatic logic [2:0] next_step(input logic [2:0] s, input cmd_t c);
    logic [2:0] n;
    unique case (s)
      STEP_START: n = STEP_SYNC;
      STEP_SYNC:  n = STEP_TYPE;
      STEP_TYPE:  n = STEP_LEN;
      STEP_LEN:   n = c.has_data ? STEP_DATA : STEP_END;
      STEP_DATA:  n = STEP_END;
      STEP_END:   n = STEP_SYNC2;
      default:    n = STEP_CSUM;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fmb_front.sv @@
`default_nettype none
module fmb_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         q_full,
  input  wire logic [7:0]   msg_type,
  input  wire logic [7:0]   payload_len,
  input  wire logic [7:0]   data_byte,
  output fmb_pkg::cmd_t     push_cmd,
  output logic              push
);

  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       accept;
  logic       too_long;

  assign accept   = in_valid && !q_full;
  assign too_long = payload_len > 8'(fmb_pkg::MAX_PAYLOAD);

  always_comb begin
    push_cmd             = '0;
    push_cmd.msg_type    = msg_type;
    push_cmd.payload_len = payload_len;
    push_cmd.data_byte   = data_byte;
    push                 = 1'b0;
    bytes_left_nxt       = bytes_left_r;
    if (accept) begin
      if (bytes_left_r == 8'd0) begin
        if (!too_long) begin
          push              = 1'b1;
          push_cmd.hdr      = 1'b1;
          push_cmd.has_data = (payload_len != 8'd0);
          push_cmd.trl      = (payload_len <= 8'd1);
          bytes_left_nxt    = (payload_len == 8'd0) ? 8'd0 : payload_len - 8'd1;
        end
      end else begin
        push              = 1'b1;
        push_cmd.has_data = 1'b1;
        push_cmd.trl      = (bytes_left_r == 8'd1);
        bytes_left_nxt    = bytes_left_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 8'd0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fmb_queue.sv @@
`default_nettype none
module fmb_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fmb_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output fmb_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);

  fmb_pkg::cmd_t mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/fmb_back.sv @@
`default_nettype none
module fmb_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fmb_pkg::cfg_t cfg,
  input  wire fmb_pkg::cmd_t head,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_byte,
  output logic               out_frame_end
);

  logic       busy_r, busy_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] cur_step;
  logic [7:0] xor_r, xor_nxt;
  logic       stopped_r, stopped_nxt;
  logic       ov_r;
  logic [7:0] ob_r;
  logic       oe_r;
  logic       load;
  logic       is_last;
  logic       summed;
  logic [7:0] b;

  assign cur_step = busy_r ? step_r : fmb_pkg::first_step(head);
  assign load     = !q_empty && (!ov_r || !out_stall);
  assign is_last  = (cur_step == fmb_pkg::STEP_CSUM) ||
                    (cur_step == fmb_pkg::STEP_DATA && !head.trl);
  assign pop      = load && is_last;

  always_comb begin
    summed = 1'b0;
    unique case (cur_step)
      fmb_pkg::STEP_START: b = cfg.start_char;
      fmb_pkg::STEP_SYNC:  begin b = cfg.sync_char;   summed = 1'b1; end
      fmb_pkg::STEP_TYPE:  begin b = head.msg_type;    summed = 1'b1; end
      fmb_pkg::STEP_LEN:   begin b = head.payload_len; summed = 1'b1; end
      fmb_pkg::STEP_DATA:  begin b = head.data_byte;   summed = 1'b1; end
      fmb_pkg::STEP_END:   begin b = cfg.end_char;     summed = 1'b1; end
      fmb_pkg::STEP_SYNC2: b = cfg.sync_char;
      default:             b = xor_r;
    endcase
  end

  always_comb begin
    xor_nxt     = xor_r;
    stopped_nxt = stopped_r;
    busy_nxt    = busy_r;
    step_nxt    = step_r;
    if (load) begin
      if (cur_step == fmb_pkg::STEP_START) begin
        xor_nxt     = 8'd0;
        stopped_nxt = 1'b0;
      end else if (summed && !stopped_r) begin
        if (b == cfg.start_char) begin
          xor_nxt = xor_r;
        end else if (b == cfg.end_char) begin
          stopped_nxt = 1'b1;
        end else begin
          xor_nxt = xor_r ^ b;
        end
      end
      busy_nxt = !is_last;
      step_nxt = fmb_pkg::next_step(cur_step, head);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      step_r    <= fmb_pkg::STEP_START;
      xor_r     <= 8'd0;
      stopped_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      step_r    <= step_nxt;
      xor_r     <= xor_nxt;
      stopped_r <= stopped_nxt;
      if (load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= b;
      oe_r <= (cur_step == fmb_pkg::STEP_CSUM);
    end
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_frame_end = oe_r;

endmodule
`default_nettype wire

@@ rtl/framed_message_builder_xor_checksum.sv @@
`default_nettype none
// Builds framed messages: the first item of a message yields start, sync, type and
// length bytes, every item passes one payload byte, and the last one adds end char,
// sync char and an XOR checksum (frame_end high on the checksum). A zero-length
// message is one item (data ignored); a first item with length above 250 is taken
// and dropped. A two-entry command queue separates the item front end from the byte
// sequencer; the sequencer emits one byte per cycle while out_stall is low, so payload
// items flow at one per cycle, and while header and trailer bytes go out in_stall
// rises once the queue fills. cfg_ready is always high; registers 0..2 are start,
// sync and end char.
module framed_message_builder_xor_checksum (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_msg_type,
  input  wire logic [7:0] in_payload_len,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_frame_end,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  fmb_pkg::cfg_t cfg_r;
  fmb_pkg::cmd_t push_cmd, head;
  logic          push, pop, q_empty, q_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_char <= fmb_pkg::START_RST;
      cfg_r.sync_char  <= fmb_pkg::SYNC_RST;
      cfg_r.end_char   <= fmb_pkg::END_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fmb_pkg::CFG_START: cfg_r.start_char <= cfg_data;
        fmb_pkg::CFG_SYNC:  cfg_r.sync_char  <= cfg_data;
        fmb_pkg::CFG_END:   cfg_r.end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  fmb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .q_full      (q_full),
    .msg_type    (in_msg_type),
    .payload_len (in_payload_len),
    .data_byte   (in_data_byte),
    .push_cmd    (push_cmd),
    .push        (push)
  );

  fmb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  fmb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire

@@ dv/framed_message_builder_xor_checksum_test.sv @@
`timescale 1ns / 1ps

module framed_message_builder_xor_checksum_test;

  // n < 0: bytes come from the predictor; else the first n bytes of frame, MSB first
  typedef struct {
    logic [7:0]  ty;
    logic [7:0]  ln;
    logic [7:0]  db;
    int          n;
    logic [63:0] frame;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fe;
  } frame_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_msg_type;
  logic [7:0] in_payload_len;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_frame_end;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  framed_message_builder_xor_checksum u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_msg_type   (in_msg_type),
    .in_payload_len(in_payload_len),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // framer model state
  logic [7:0] r_start = fmb_pkg::START_RST;
  logic [7:0] r_sync  = fmb_pkg::SYNC_RST;
  logic [7:0] r_end   = fmb_pkg::END_RST;
  logic [7:0] open_left = '0;
  logic [7:0] csum = '0;
  logic       csum_stop = 1'b0;

  frame_byte_t pending_bytes[$];
  frame_byte_t fresh_bytes[$];
  stim_row_t   dir_rows[$];
  stim_row_t   cur_row;

  int errs = 0;
  int quiet = 0;
  int tx_idle = 29;
  int rx_idle = 74;
  bit press_go = 1'b0;
  int press_cnt = 0;
  int msg_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit_raw(logic [7:0] b, logic fe);
    fresh_bytes.push_back('{b: b, fe: fe});
  endfunction

  function automatic void emit_covered(logic [7:0] b);
    if (!csum_stop) begin
      if (b == r_start) begin
      end else if (b == r_end) begin
        csum_stop = 1'b1;
      end else begin
        csum = csum ^ b;
      end
    end
    emit_raw(b, 1'b0);
  endfunction

  function automatic void emit_trailer();
    emit_covered(r_end);
    emit_raw(r_sync, 1'b0);
    emit_raw(csum, 1'b1);
  endfunction

  function automatic void frame_item(logic [7:0] ty, logic [7:0] ln, logic [7:0] db);
    if (open_left == 0) begin
      if (ln > fmb_pkg::MAX_PAYLOAD) return;
      csum = '0;
      csum_stop = 1'b0;
      emit_raw(r_start, 1'b0);
      emit_covered(r_sync);
      emit_covered(ty);
      emit_covered(ln);
      if (ln == 0) begin
        emit_trailer();
        return;
      end
      open_left = ln;
    end
    emit_covered(db);
    open_left = open_left - 8'd1;
    if (open_left == 0) emit_trailer();
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return r_start;
      1: return r_sync;
      2: return r_end;
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fmb_pkg::CFG_START: r_start = cfg_data;
        fmb_pkg::CFG_SYNC:  r_sync = cfg_data;
        fmb_pkg::CFG_END:   r_end = cfg_data;
        default: ;
      endcase
    end
    if (in_valid && !in_stall) begin
      fresh_bytes.delete();
      frame_item(in_msg_type, in_payload_len, in_data_byte);
      if (cur_row.n >= 0) begin
        for (int k = 0; k < cur_row.n; k++)
          pending_bytes.push_back('{b: cur_row.frame[63 - 8 * k -: 8], fe: k == cur_row.n - 1});
      end else begin
        foreach (fresh_bytes[k]) pending_bytes.push_back(fresh_bytes[k]);
      end
    end
    if (out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("out_byte: expected nothing, got %0h", out_byte);
        errs++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.b) begin
          $error("out_byte: expected %0h, got %0h", want.b, out_byte);
          errs++;
        end
        if (out_frame_end !== want.fe) begin
          $error("out_frame_end: expected %0b, got %0b", want.fe, out_frame_end);
          errs++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == 4000) begin
        $display("framed_message_builder_xor_checksum_test: errors");
        $finish;
      end
    end
  end

  // receiver side; one long hold-off once pressure is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (press_go && press_cnt < 400) begin
        out_stall <= 1'b1;
        press_cnt++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle);
      end
    end
  end

  task automatic send_item(stim_row_t r);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cur_row = r;
    in_valid <= 1'b1;
    in_msg_type <= r.ty;
    in_payload_len <= r.ln;
    in_data_byte <= r.db;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(logic [7:0] s, logic [7:0] y, logic [7:0] e);
    write_reg(fmb_pkg::CFG_START, s);
    write_reg(fmb_pkg::CFG_SYNC, y);
    write_reg(fmb_pkg::CFG_END, e);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_traffic(int target, bit big_first);
    stim_row_t r;
    int taken;
    int sel;
    taken = 0;
    while (taken < target) begin
      r.n = -1;
      r.frame = '0;
      r.ty = pick_byte();
      r.db = pick_byte();
      r.ln = 8'($urandom);
      if (msg_left == 0) begin
        if (big_first) begin
          r.ln = 8'(fmb_pkg::MAX_PAYLOAD);
          big_first = 1'b0;
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 6) r.ln = 8'($urandom_range(fmb_pkg::MAX_PAYLOAD + 1, 255));
          else if (sel < 22) r.ln = 8'd0;
          else if (sel < 30) r.ln = 8'($urandom_range(9, 40));
          else r.ln = 8'($urandom_range(1, 8));
        end
        if (r.ln <= fmb_pkg::MAX_PAYLOAD) begin
          taken++;
          msg_left = (r.ln == 0) ? 0 : r.ln - 1;
        end
      end else begin
        taken++;
        msg_left--;
      end
      send_item(r);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_msg_type = '0;
    in_payload_len = '0;
    in_data_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = fmb_pkg::CFG_START;
    cfg_data = '0;
    cur_row = '{8'h00, 8'h00, 8'h00, -1, 64'h0};

    // default registers: start 24, sync 40, end 2A
    dir_rows.push_back('{8'h00, 8'h00, 8'hFF, 7, 64'h2440_0000_2A40_4000});
    dir_rows.push_back('{8'h11, 8'hFB, 8'h00, 0, 64'h0});
    dir_rows.push_back('{8'hFF, 8'hFF, 8'hFF, 0, 64'h0});
    dir_rows.push_back('{8'h01, 8'h01, 8'h10, 8, 64'h2440_0101_102A_4050});
    dir_rows.push_back('{8'hFF, 8'h03, 8'h24, -1, 64'h0});
    dir_rows.push_back('{8'hAA, 8'hFF, 8'h2A, -1, 64'h0});
    dir_rows.push_back('{8'h55, 8'h00, 8'h00, -1, 64'h0});
    dir_rows.push_back('{8'h2A, 8'h02, 8'hFF, -1, 64'h0});
    dir_rows.push_back('{8'h00, 8'h80, 8'h55, -1, 64'h0});
    dir_rows.push_back('{8'h24, 8'h01, 8'h40, -1, 64'h0});
    dir_rows.push_back('{8'h40, 8'h00, 8'h00, -1, 64'h0});
    dir_rows.push_back('{8'h7F, 8'h04, 8'hFF, -1, 64'h0});
    dir_rows.push_back('{8'h00, 8'h00, 8'hAA, -1, 64'h0});
    dir_rows.push_back('{8'h01, 8'h01, 8'h2A, -1, 64'h0});
    dir_rows.push_back('{8'hFF, 8'hFF, 8'h00, -1, 64'h0});
    dir_rows.push_back('{8'h12, 8'hFC, 8'h34, 0, 64'h0});
    dir_rows.push_back('{8'h2A, 8'h2A, 8'h24, -1, 64'h0});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    @(negedge clk);
    in_valid <= 1'b0;
    msg_left = 42 - 1;
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tx_idle = 74;
        rx_idle = 29;
      end
      if (p == 4) begin
        tx_idle = 0;
        rx_idle = 0;
        press_go = 1'b1;
      end
      case (p)
        0: set_regs(8'h00, 8'h00, 8'h00);
        1: set_regs(8'hFF, 8'hFF, 8'hFF);
        2: set_regs(8'hFF, 8'h00, 8'h80);
        5: set_regs(fmb_pkg::START_RST, fmb_pkg::SYNC_RST, fmb_pkg::END_RST);
        default: set_regs(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      run_traffic(80, p == 5);
      wait_drained();
    end

    if (pending_bytes.size() != 0) begin
      $error("out_byte: %0d expected bytes never arrived", pending_bytes.size());
      errs++;
    end
    if (errs == 0) begin
      $display("framed_message_builder_xor_checksum_test: clean");
    end else begin
      $display("framed_message_builder_xor_checksum_test: errors");
    end
    $finish;
  end

endmodule

@@ framed_message_builder_xor_checksum.f @@
rtl/fmb_pkg.sv
rtl/fmb_front.sv
rtl/fmb_queue.sv
rtl/fmb_back.sv
rtl/framed_message_builder_xor_checksum.sv
dv/framed_message_builder_xor_checksum_test.sv
